FILE: src/caseless_word_start_search_core_assert.svh
// Assertion macros shared by the caseless word-start search RTL.
`ifndef CASELESS_WORD_START_SEARCH_CORE_ASSERT_SVH
`define CASELESS_WORD_START_SEARCH_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define CWSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CWSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/cwss_pkg.sv
// Shared types, constants and helpers for the caseless word-start search.
`default_nettype none

package cwss_pkg;

	localparam int WINDOW     = 16;
	localparam int MAX_TARGET = 16;
	localparam int LEN_CAP    = (MAX_TARGET < WINDOW) ? MAX_TARGET : WINDOW;
	localparam int LEN_W      = 5;
	localparam int POS_W      = 16;
	localparam int CFG_W      = 64;
	localparam int ADDR_W     = 5;

	localparam logic [7:0] SEP_LIMIT     = 8'd32;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET   = 8'd32;

	localparam logic [POS_W-1:0] COUNT_MAX = '1;

	typedef logic [7:0] byte_t;
	typedef logic [WINDOW-1:0][7:0] window_t;
	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_TARGET_LENGTH = 2'd0;
	localparam reg_idx_t REG_TARGET_LOW    = 2'd1;
	localparam reg_idx_t REG_TARGET_HIGH   = 2'd2;

	// Window contents handed from the shift stage to the compare logic.
	typedef struct packed {
		window_t             win;
		logic [WINDOW-1:0]   marks;
	} scan_t;

	function automatic byte_t fold(input byte_t c);
		return (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) ? c - CASE_OFFSET : c;
	endfunction

endpackage

`default_nettype wire

FILE: src/caseless_word_start_search_core.sv
// An end_of_text item is registered in the shift stage; its result then goes to the result register.
// Throughput: one text item per cycle; the only stall comes from a held result.
// The window compare is combinational, between the shift stage and the result register.
// Reset clears the position counter, the found state, the target registers and all valid flags; no clearing pass.
// After each end_of_text item the scan state starts over for the next text.
`default_nettype none

`include "caseless_word_start_search_core_assert.svh"

module caseless_word_start_search_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration port
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [cwss_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [cwss_pkg::CFG_W-1:0]       pwdata,
	output logic      [cwss_pkg::CFG_W-1:0]       prdata,
	output logic                                  pready,
	// text channel
	input  wire logic                             text_valid,
	output logic                                  text_stall,
	input  wire logic [7:0]                       text_byte,
	input  wire logic                             end_of_text,
	// result channel
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic                                  match_found,
	output logic      [cwss_pkg::POS_W-1:0]       match_position,
	output logic      [cwss_pkg::LEN_W-1:0]       match_length
);

	// ---------------- configuration registers ----------------
	logic [cwss_pkg::LEN_W-1:0] target_length_q;
	logic [cwss_pkg::CFG_W-1:0] target_low_q;
	logic [cwss_pkg::CFG_W-1:0] target_high_q;
	cwss_pkg::reg_idx_t         reg_idx;
	logic                       cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[4:3];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_length_q <= '0;
			target_low_q    <= '0;
			target_high_q   <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				cwss_pkg::REG_TARGET_LENGTH: target_length_q <= pwdata[cwss_pkg::LEN_W-1:0];
				cwss_pkg::REG_TARGET_LOW:    target_low_q    <= pwdata;
				cwss_pkg::REG_TARGET_HIGH:   target_high_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			cwss_pkg::REG_TARGET_LENGTH:
				prdata = {{(cwss_pkg::CFG_W-cwss_pkg::LEN_W){1'b0}}, target_length_q};
			cwss_pkg::REG_TARGET_LOW:  prdata = target_low_q;
			cwss_pkg::REG_TARGET_HIGH: prdata = target_high_q;
			default:                   prdata = '0;
		endcase
	end

	logic [cwss_pkg::LEN_W-1:0] eff_len;
	cwss_pkg::window_t          target;

	assign eff_len = (target_length_q > cwss_pkg::LEN_W'(cwss_pkg::LEN_CAP)) ?
		cwss_pkg::LEN_W'(cwss_pkg::LEN_CAP) : target_length_q;
	assign target  = {target_high_q, target_low_q};

	// ---------------- handshake ----------------
	logic valid_s1;
	logic last_s1;
	logic out_free;
	logic s1_move;
	logic text_take;
	logic proc;

	assign out_free   = !result_valid || !result_stall;
	assign s1_move    = !last_s1 || out_free;
	assign text_stall = valid_s1 && !s1_move;
	assign text_take  = text_valid && !text_stall;
	assign proc       = valid_s1 && s1_move;

	// ---------------- shift stage ----------------
	cwss_pkg::scan_t            scan_s1;
	logic [cwss_pkg::POS_W-1:0] cnt_s1;
	logic [cwss_pkg::POS_W-1:0] ctr_q;
	logic                       prev_sep_q;
	logic                       fresh_q;
	cwss_pkg::scan_t            base;
	cwss_pkg::scan_t            scan_next;
	logic                       sep;

	// A fresh text shifts in from an empty window.
	assign base = fresh_q ? '0 : scan_s1;
	assign sep  = text_byte <= cwss_pkg::SEP_LIMIT;

	always_comb begin
		scan_next.win   = {base.win[cwss_pkg::WINDOW-2:0], text_byte};
		scan_next.marks = {base.marks[cwss_pkg::WINDOW-2:0], !sep && prev_sep_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fresh_q    <= 1'b1;
			ctr_q      <= '0;
			prev_sep_q <= 1'b1;
		end else begin
			if (text_take) begin
				valid_s1 <= 1'b1;
				fresh_q  <= end_of_text;
				if (end_of_text) begin
					ctr_q      <= '0;
					prev_sep_q <= 1'b1;
				end else begin
					ctr_q      <= (ctr_q == cwss_pkg::COUNT_MAX) ? ctr_q : ctr_q + 1'b1;
					prev_sep_q <= sep;
				end
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_take) begin
			scan_s1 <= scan_next;
			cnt_s1  <= ctr_q;
			last_s1 <= end_of_text;
		end
	end

	// ---------------- compare and result stage ----------------
	logic                       hit;
	logic                       take_hit;
	logic                       found_q;
	logic [cwss_pkg::POS_W-1:0] found_off_q;
	logic [cwss_pkg::POS_W-1:0] hit_off;

	cwss_match u_match (
		.scan   (scan_s1),
		.target (target),
		.len    (eff_len),
		.hit    (hit)
	);

	assign take_hit = !found_q && (cnt_s1 != cwss_pkg::COUNT_MAX) && hit;
	assign hit_off  = (eff_len == '0) ? cnt_s1 :
		cnt_s1 - cwss_pkg::POS_W'(eff_len) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			found_off_q  <= '0;
			result_valid <= 1'b0;
		end else begin
			if (proc) begin
				if (last_s1) begin
					found_q     <= 1'b0;
					found_off_q <= '0;
				end else if (take_hit) begin
					found_q     <= 1'b1;
					found_off_q <= hit_off;
				end
			end
			if (proc && last_s1) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			match_found    <= found_q || take_hit;
			match_position <= found_q ? found_off_q : (take_hit ? hit_off : '0);
			match_length   <= (found_q || take_hit) ? eff_len : '0;
		end
	end

	// ---------------- assertions ----------------
	`CWSS_ASSERT_NOW(a_empty_result, result_valid && !match_found,
		match_position == '0 && match_length == '0, "empty result carries data")
	`CWSS_ASSERT_NOW(a_len_cap, result_valid,
		match_length <= cwss_pkg::LEN_W'(cwss_pkg::LEN_CAP), "result length above cap")
	`CWSS_ASSERT_NEXT(a_restart, proc && last_s1,
		!found_q && result_valid, "scan state not restarted after end of text")
	`CWSS_ASSERT_NEXT(a_fresh, text_take && end_of_text,
		fresh_q && ctr_q == '0, "next text does not start empty")

endmodule

`default_nettype wire

FILE: src/cwss_match.sv
// Caseless compare of the recent-byte window against the target at a word start.
`default_nettype none

module cwss_match (
	input  wire cwss_pkg::scan_t              scan,
	input  wire cwss_pkg::window_t            target,
	input  wire logic [cwss_pkg::LEN_W-1:0]   len,
	output logic                              hit
);

	logic [cwss_pkg::WINDOW-1:0] eq;
	logic [3:0]                  start_idx;

	// Byte k of the target lines up with the byte (len-1-k) steps back.
	always_comb begin
		for (int k = 0; k < cwss_pkg::WINDOW; k++) begin
			logic [3:0] idx;
			idx = 4'(len - 5'(k) - 5'd1);
			eq[k] = (5'(k) >= len) ||
				(cwss_pkg::fold(scan.win[idx]) == cwss_pkg::fold(target[k]));
		end
	end

	assign start_idx = 4'(len - 5'd1);

	always_comb begin
		if (len == '0) begin
			hit = scan.marks[0];
		end else begin
			hit = scan.marks[start_idx] && (&eq);
		end
	end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the caseless word-start search core.
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_LIMIT    = 1000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AFTER     = 15;
	localparam int PHASE_ITEMS    = 115;
	localparam int RANDOM_PHASES  = 6;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} text_item_t;

	typedef struct {
		logic                       found;
		logic [cwss_pkg::POS_W-1:0] pos;
		logic [cwss_pkg::LEN_W-1:0] len;
	} match_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [cwss_pkg::ADDR_W-1:0] paddr = '0;
	logic [cwss_pkg::CFG_W-1:0]  pwdata = '0;
	logic [cwss_pkg::CFG_W-1:0]  prdata;
	logic                        pready;
	logic                        text_valid = 1'b0;
	logic                        text_stall;
	logic [7:0]                  text_byte = '0;
	logic                        end_of_text = 1'b0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	logic                        match_found;
	logic [cwss_pkg::POS_W-1:0]  match_position;
	logic [cwss_pkg::LEN_W-1:0]  match_length;

	caseless_word_start_search_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.text_valid     (text_valid),
		.text_stall     (text_stall),
		.text_byte      (text_byte),
		.end_of_text    (end_of_text),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.match_found    (match_found),
		.match_position (match_position),
		.match_length   (match_length)
	);

	// register mirror
	logic [cwss_pkg::LEN_W-1:0] tgt_len = '0;
	logic [63:0]                tgt_low = '0;
	logic [63:0]                tgt_high = '0;

	// scan state of the predictor
	logic [7:0]                 recent [cwss_pkg::WINDOW];
	logic [15:0]                start_marks;
	logic [cwss_pkg::POS_W-1:0] offset_count;
	logic                       prev_sep;
	logic                       have_match;
	logic [cwss_pkg::POS_W-1:0] match_at;

	text_item_t pending_bytes [$];
	match_t     expected_matches [$];

	bit no_idle = 1'b0;
	int error_count = 0;
	int bytes_accepted = 0;
	int results_checked = 0;
	int stall_cycles = 0;
	int cfg_writes = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_len();
		return (int'(tgt_len) > cwss_pkg::LEN_CAP) ? cwss_pkg::LEN_CAP : int'(tgt_len);
	endfunction

	function automatic logic [7:0] target_at(input int k);
		return (k < 8) ? tgt_low[8*k +: 8] : tgt_high[8*(k-8) +: 8];
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	function automatic logic [63:0] random_letters();
		logic [63:0] w;
		logic [7:0]  c;
		for (int i = 0; i < 8; i++) begin
			c = 8'h41 + 8'($urandom_range(0, 25));
			w[8*i +: 8] = $urandom_range(0, 1) ? (c | 8'h20) : c;
		end
		return w;
	endfunction

	task automatic clear_scan();
		for (int i = 0; i < cwss_pkg::WINDOW; i++)
			recent[i] = '0;
		start_marks = '0;
		offset_count = '0;
		prev_sep = 1'b1;
		have_match = 1'b0;
		match_at = '0;
	endtask

	// Advance the search by one text item; emit the verdict on the last one.
	task automatic scan_text_byte(input logic [7:0] b, input logic last);
		logic   sep;
		int     n;
		bit     hit;
		match_t res;
		sep = (b <= 8'd32);
		n = eff_len();
		for (int i = cwss_pkg::WINDOW - 1; i > 0; i--)
			recent[i] = recent[i-1];
		recent[0] = b;
		start_marks = {start_marks[14:0], !sep && prev_sep};
		prev_sep = sep;
		if (!have_match && offset_count != cwss_pkg::COUNT_MAX) begin
			if (n == 0) begin
				if (start_marks[0]) begin
					have_match = 1'b1;
					match_at = offset_count;
				end
			end else if (start_marks[n-1]) begin
				hit = 1'b1;
				for (int k = 0; k < n; k++)
					if (upcase(recent[n-1-k]) != upcase(target_at(k)))
						hit = 1'b0;
				if (hit) begin
					have_match = 1'b1;
					match_at = offset_count - cwss_pkg::POS_W'(n - 1);
				end
			end
		end
		if (offset_count != cwss_pkg::COUNT_MAX)
			offset_count++;
		if (last) begin
			res.found = have_match;
			res.pos = have_match ? match_at : '0;
			res.len = have_match ? cwss_pkg::LEN_W'(n) : '0;
			expected_matches.push_back(res);
			clear_scan();
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		text_item_t it;
		it.ch = b;
		it.last = last;
		pending_bytes.push_back(it);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], i == s.len() - 1);
	endtask

	task automatic write_reg(input cwss_pkg::reg_idx_t idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			cwss_pkg::REG_TARGET_LENGTH: tgt_len = value[cwss_pkg::LEN_W-1:0];
			cwss_pkg::REG_TARGET_LOW:    tgt_low = value;
			cwss_pkg::REG_TARGET_HIGH:   tgt_high = value;
			default: ;
		endcase
		cfg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() != 0 || text_valid || expected_matches.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Build one text: mostly words and target copies behind separators, some raw noise.
	task automatic queue_random_text(output int count);
		logic [7:0] txt [$];
		int         kind;
		int         cut;
		logic [7:0] b;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 20)) txt.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(1, 4)) begin
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					if ($urandom_range(0, 3) != 0)
						txt.push_back(8'($urandom_range(1, 32)));
					cut = eff_len();
					// drop the tail now and then to get near misses
					if (cut > 0 && $urandom_range(0, 4) == 0)
						cut = $urandom_range(0, cut - 1);
					for (int k = 0; k < cut; k++) begin
						b = target_at(k);
						if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 1))
							b = b ^ 8'h20;
						txt.push_back(b);
					end
				end else if (kind < 8) begin
					txt.push_back(8'($urandom_range(1, 32)));
				end else begin
					repeat ($urandom_range(1, 5)) txt.push_back(8'($urandom_range(33, 255)));
				end
			end
		end
		if (txt.size() == 0)
			txt.push_back(8'($urandom_range(33, 255)));
		for (int i = 0; i < txt.size(); i++)
			push_byte(txt[i], i == txt.size() - 1);
		count = txt.size();
	endtask

	task automatic flag_result(input string what, input match_t want);
		error_count++;
		if (error_count <= 10)
			$display("ERROR %s: want found=%0d pos=%0d len=%0d, got found=%0d pos=%0d len=%0d",
				what, want.found, want.pos, want.len, match_found, match_position, match_length);
	endtask

	// text driver
	text_item_t cur_item;
	int         gap_left = 0;
	bit         text_took;

	always @(posedge clk) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			gap_left = 0;
		end else begin
			text_took = text_valid && !text_stall;
			if (text_took) begin
				scan_text_byte(text_byte, end_of_text);
				bytes_accepted++;
			end
			if (text_valid && text_stall)
				stall_cycles++;
			if (!text_valid || text_took) begin
				if (gap_left != 0) begin
					gap_left--;
					text_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					cur_item = pending_bytes.pop_front();
					text_byte <= cur_item.ch;
					end_of_text <= cur_item.last;
					text_valid <= 1'b1;
					gap_left = no_idle ? 0 : $urandom_range(0, 11);
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	int     rx_wait = 0;
	int     hold_left = 0;
	bit     pressure_done = 1'b0;
	match_t want;
	match_t none_expected = '{default: '0};

	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				results_checked++;
				if (expected_matches.size() == 0) begin
					flag_result("unexpected result", none_expected);
				end else begin
					want = expected_matches.pop_front();
					if (match_found !== want.found || match_position !== want.pos ||
						match_length !== want.len)
						flag_result("result mismatch", want);
				end
				rx_wait = no_idle ? 0 : $urandom_range(0, 11);
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			// hold off once for a long stretch so the text side backs up
			if (hold_left != 0) begin
				hold_left--;
			end else if (!pressure_done && results_checked >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			result_stall <= (rx_wait != 0) || (hold_left != 0);
		end
	end

	// watchdog
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((text_valid && !text_stall) || (result_valid && !result_stall) ||
			(psel && penable && pwrite && pready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("** caseless_word_start_search_core: FAILED **");
				$finish;
			end
		end
	end

	int          queued;
	int          n_items;
	int          drain;
	logic [4:0]  ph_len;
	logic [63:0] ph_low;
	logic [63:0] ph_high;

	initial begin
		clear_scan();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty target at reset: first word start, then a text of separators only
		send_str(" x");
		send_str("  ");
		wait_idle();

		// zero target byte, zero text byte, case fold, high byte blocking a word start,
		// match past the end
		write_reg(cwss_pkg::REG_TARGET_LENGTH, 64'd2);
		write_reg(cwss_pkg::REG_TARGET_LOW, 64'h0061);
		push_byte(8'h41, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'h80, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'h41, 1'b1);
		wait_idle();

		// overlong length saturates to the window; all-ones target
		write_reg(cwss_pkg::REG_TARGET_LENGTH, 64'd31);
		write_reg(cwss_pkg::REG_TARGET_LOW, '1);
		write_reg(cwss_pkg::REG_TARGET_HIGH, '1);
		for (int i = 0; i < 16; i++)
			push_byte(8'hFF, i == 15);
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			ph_low = random_letters();
			ph_high = random_letters();
			case (ph)
				0: ph_len = 5'd16;
				1: ph_len = 5'd1;
				2: ph_len = 5'd0;
				3: begin
					ph_len = 5'd31;
					ph_low = '1;
				end
				4: ph_len = 5'($urandom_range(2, 15));
				default: begin
					ph_len = 5'd9;
					ph_high = '1;
				end
			endcase
			write_reg(cwss_pkg::REG_TARGET_LENGTH, 64'(ph_len));
			write_reg(cwss_pkg::REG_TARGET_LOW, ph_low);
			write_reg(cwss_pkg::REG_TARGET_HIGH, ph_high);
			no_idle = ($urandom_range(0, 3) == 0);
			queued = 0;
			while (queued < PHASE_ITEMS) begin
				queue_random_text(n_items);
				queued += n_items;
			end
			wait_idle();
		end

		while (pending_bytes.size() != 0 || text_valid)
			@(negedge clk);
		drain = 0;
		while (expected_matches.size() != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_matches.size() != 0) begin
			error_count++;
			$display("ERROR %0d expected results never arrived", expected_matches.size());
		end

		$display("covered %0d text bytes and %0d results over %0d register writes",
			bytes_accepted, results_checked, cfg_writes);
		$display("text side saw %0d stalled cycles; %0d errors", stall_cycles, error_count);
		if (error_count == 0) begin
			$display("** caseless_word_start_search_core: PASSED **");
		end else begin
			$display("** caseless_word_start_search_core: FAILED **");
		end
		$finish;
	end

endmodule
